>>> sv/fixed_point_alu_defines.svh
// assertion macros for the fixed-point alu
`ifndef FIXED_POINT_ALU_DEFINES_SVH
`define FIXED_POINT_ALU_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define FPA_ASSERT_IMP(label, lhs, rhs) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");
// next-cycle implication checked outside reset
`define FPA_ASSERT_NEXT(label, lhs, rhs) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");
`endif

>>> sv/fpa_pkg.sv
// shared types and constants of the fixed-point alu
package fpa_pkg;
    localparam int FracBits = 8;
    // restoring divider: quotient bits of (2*num+den)/(2*den)
    localparam int NumW = 33 + FracBits;
    localparam int QW   = NumW;
    localparam int NStages = QW;

    typedef enum logic [3:0] {
        CMD_ADD = 4'd0, CMD_SUB = 4'd1, CMD_MUL = 4'd2, CMD_DIV = 4'd3,
        CMD_LT = 4'd4, CMD_GT = 4'd5, CMD_LE = 4'd6, CMD_GE = 4'd7,
        CMD_EQ = 4'd8, CMD_NE = 4'd9, CMD_MIN = 4'd10, CMD_MAX = 4'd11,
        CMD_INC = 4'd12, CMD_DEC = 4'd13, CMD_FROM_INT = 4'd14, CMD_TO_INT = 4'd15
    } t_cmd;

    // one item travelling down the cell row
    typedef struct packed {
        logic              valid;
        t_cmd              cmd;
        logic              neg;
        logic              dz;
        logic              fast_cmp;
        logic              fast_ovf;
        logic [31:0]       fast_word;
        logic [64:0]       mag;     // mul magnitude or divider numerator
        logic [NumW:0]     den2;    // 2*den
        logic [NumW:0]     rem;
        logic [QW-1:0]     quo;
    } t_item;

    // saturated word from sign and magnitude
    function automatic logic [32:0] sat_mag(input logic neg, input logic [64:0] mag);
        logic [32:0] r;
        begin
            if (neg) begin
                if (mag > 65'h080000000) r = {1'b1, 32'h80000000};
                else r = {1'b0, 32'(~mag[31:0] + 32'd1)};
            end else begin
                if (mag > 65'h07fffffff) r = {1'b1, 32'h7fffffff};
                else r = {1'b0, mag[31:0]};
            end
            return r;
        end
    endfunction
endpackage

>>> sv/fixed_point_alu.sv
// top level of the pipelined fixed-point alu
// Usage: one operation per transfer on the s_axis channel, one result per
// transfer on the m_axis channel, in order. s_axis_tdata carries cmd,
// operand_a, operand_b; m_axis_tdata carries result_word, compare_true,
// overflowed, divide_by_zero. Every operation runs through the same chain:
// an entry cell, then one cell per quotient bit (41 cells at 8 fraction
// bits) and an output register, for every command. The divider cell row
// sets the depth of the chain; throughput is one item per cycle unless the
// output stalls. Multiply rounds in divider cell zero; the rest pass through.
// When the receiver stalls (m_axis_tready low) with a result waiting, the
// whole chain holds and s_axis_tready drops, even if the chain still has
// bubbles. Synchronous active-low reset empties the chain.
module fixed_point_alu
    import fpa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // cmd[3:0], operand_a[35:4], operand_b[67:36]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // result_word[31:0], compare_true, overflowed, divide_by_zero
);
`include "fixed_point_alu_defines.svh"
    t_item chain [0:NStages];
    logic en;
    logic r_valid;
    logic [34:0] r_data, n_data;
    logic [32:0] sat;

    // chain advances unless the output holds an untaken result
    assign en = !r_valid || m_axis_tready;
    assign s_axis_tready = en;

    fpa_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(s_axis_tvalid),
        .i_cmd(s_axis_tdata[3:0]), .i_a(s_axis_tdata[35:4]), .i_b(s_axis_tdata[67:36]),
        .o_item(chain[0])
    );

    for (genvar g = 0; g < NStages; g++) begin : g_cell
        fpa_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_idx(($clog2(NStages+1))'(g)),
            .i_item(chain[g]), .o_item(chain[g+1])
        );
    end

    // final result selection
    always_comb begin
        sat = sat_mag(chain[NStages].neg, chain[NStages].cmd == CMD_DIV
                      ? 65'(chain[NStages].quo) : chain[NStages].mag);
        n_data = {chain[NStages].fast_word, chain[NStages].fast_cmp,
                  chain[NStages].fast_ovf, 1'b0};
        if (chain[NStages].cmd == CMD_MUL) begin
            n_data = {sat[31:0], 1'b0, sat[32], 1'b0};
        end else if (chain[NStages].cmd == CMD_DIV) begin
            if (chain[NStages].dz) n_data = {32'd0, 1'b0, 1'b0, 1'b1};
            else n_data = {sat[31:0], 1'b0, sat[32], 1'b0};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= chain[NStages].valid;
            r_data  <= n_data;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata = {5'd0, r_data[0], r_data[1], r_data[2], r_data[34:3]};

    `FPA_ASSERT_IMP(a_ready_free, !r_valid, s_axis_tready)
    `FPA_ASSERT_IMP(a_flags_excl, r_valid, !(r_data[0] && r_data[1]))
    `FPA_ASSERT_NEXT(a_hold, r_valid && !m_axis_tready, r_valid && $stable(r_data))
endmodule

>>> sv/fpa_front.sv
// entry cell: decode, simple operations, multiply and divider setup
module fpa_front
    import fpa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [3:0]  i_cmd,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output t_item       o_item
);
    t_item r_item, n_item;
    logic signed [33:0] sum, dif, incv, decv;
    logic signed [32:0] sa, sb;
    logic [31:0] ma, mb;
    logic [63:0] prod;
    logic [63:0] tmp;
    logic signed [32+FracBits:0] fi;

    // combinational work of the first cell
    always_comb begin
        sa = $signed({i_a[31], i_a});
        sb = $signed({i_b[31], i_b});
        ma = i_a[31] ? 32'(-i_a) : i_a;
        mb = i_b[31] ? 32'(-i_b) : i_b;
        sum  = 34'(sa) + 34'(sb);
        dif  = 34'(sa) - 34'(sb);
        incv = 34'(sa) + 34'sd1;
        decv = 34'(sa) - 34'sd1;
        fi   = $signed({i_a[31], i_a, {FracBits{1'b0}}});
        prod = 64'(ma) * 64'(mb);
        tmp = '0;
        n_item = '0;
        n_item.valid = i_valid;
        n_item.cmd = t_cmd'(i_cmd);
        n_item.neg = i_a[31] ^ i_b[31];
        unique case (t_cmd'(i_cmd))
            CMD_ADD: begin
                n_item.fast_ovf = sum > 34'sh7fffffff || sum < -34'sh80000000;
                n_item.fast_word = n_item.fast_ovf ? (sum[33] ? 32'h80000000 : 32'h7fffffff)
                                                   : sum[31:0];
            end
            CMD_SUB: begin
                n_item.fast_ovf = dif > 34'sh7fffffff || dif < -34'sh80000000;
                n_item.fast_word = n_item.fast_ovf ? (dif[33] ? 32'h80000000 : 32'h7fffffff)
                                                   : dif[31:0];
            end
            CMD_INC: begin
                n_item.fast_ovf = incv > 34'sh7fffffff;
                n_item.fast_word = n_item.fast_ovf ? 32'h7fffffff : incv[31:0];
            end
            CMD_DEC: begin
                n_item.fast_ovf = decv < -34'sh80000000;
                n_item.fast_word = n_item.fast_ovf ? 32'h80000000 : decv[31:0];
            end
            CMD_FROM_INT: begin
                n_item.fast_ovf = fi > $signed((33+FracBits)'(34'sh7fffffff))
                               || fi < $signed((33+FracBits)'(-34'sh80000000));
                n_item.fast_word = n_item.fast_ovf ? (i_a[31] ? 32'h80000000 : 32'h7fffffff)
                                                   : fi[31:0];
            end
            CMD_TO_INT: n_item.fast_word = 32'($signed(i_a) >>> FracBits);
            CMD_LT: n_item.fast_cmp = sa < sb;
            CMD_GT: n_item.fast_cmp = sa > sb;
            CMD_LE: n_item.fast_cmp = sa <= sb;
            CMD_GE: n_item.fast_cmp = sa >= sb;
            CMD_EQ: n_item.fast_cmp = i_a == i_b;
            CMD_NE: n_item.fast_cmp = i_a != i_b;
            CMD_MIN: n_item.fast_word = (sa < sb) ? i_a : i_b;
            CMD_MAX: n_item.fast_word = (sa > sb) ? i_a : i_b;
            CMD_MUL: n_item.mag = 65'(prod);
            CMD_DIV: begin
                n_item.dz = (i_b == 32'd0);
                tmp = 64'({ma, {FracBits{1'b0}}});
                n_item.mag = 65'({tmp, 1'b0}) + 65'(mb);
                n_item.den2 = (NumW+1)'({mb, 1'b0});
            end
            default: ;
        endcase
    end

    // cell register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;
endmodule

>>> sv/fpa_cell.sv
// one divider cell: a restoring step yielding one quotient bit; mul rounding in cell zero
module fpa_cell
    import fpa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic [$clog2(NStages+1)-1:0] i_idx,
    input  t_item       i_item,
    output t_item       o_item
);
    t_item r_item, n_item;
    logic [NumW:0] trial;
    logic [65:0] half;

    // shift in the next numerator bit and try a subtract
    always_comb begin
        n_item = i_item;
        trial = {i_item.rem[NumW-1:0], i_item.mag[NumW-1 - 32'(i_idx)]};
        if (i_item.cmd == CMD_DIV) begin
            if (trial >= i_item.den2) begin
                n_item.rem = trial - i_item.den2;
                n_item.quo = {i_item.quo[QW-2:0], 1'b1};
            end else begin
                n_item.rem = trial;
                n_item.quo = {i_item.quo[QW-2:0], 1'b0};
            end
        end
        // mul rounding is handled in cell zero
        half = '0;
        if (i_item.cmd == CMD_MUL && i_idx == '0) begin
            if (FracBits > 0) half = 66'(1) << (FracBits - 1);
            n_item.mag = 65'((66'(i_item.mag) + half) >> FracBits);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;
endmodule

>>> tb/fixed_point_alu_checker.sv
// checker for the fixed-point alu: predicts each result and compares it
module fixed_point_alu_checker
    import fpa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [71:0] i_in_data,   // cmd[3:0], operand_a[35:4], operand_b[67:36]
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [39:0] i_out_data,  // result_word[31:0], compare_true, overflowed, divide_by_zero
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        div_zero;
        logic        ovf;
        logic        cmp;
        logic [31:0] word;
    } t_alu_result;

    t_alu_result expected_results[$];

    // saturate a wide signed value to 32 bits
    function automatic logic [32:0] saturate(input logic signed [79:0] v);
        if (v > 80'sd2147483647) return {1'b1, 32'h7fffffff};
        if (v < -80'sd2147483648) return {1'b1, 32'h80000000};
        return {1'b0, v[31:0]};
    endfunction

    // expected result of one operation
    function automatic t_alu_result compute_alu(input t_cmd op,
            input logic signed [31:0] a, input logic signed [31:0] b);
        t_alu_result res;
        logic signed [79:0] wa, wb, q;
        logic [79:0] ma, mb, mq;
        logic [32:0] s;
        res = '0;
        wa = a;
        wb = b;
        ma = (a < 0) ? -wa : wa;
        mb = (b < 0) ? -wb : wb;
        case (op)
            CMD_ADD: begin s = saturate(wa + wb); {res.ovf, res.word} = s; end
            CMD_SUB: begin s = saturate(wa - wb); {res.ovf, res.word} = s; end
            CMD_INC: begin s = saturate(wa + 1); {res.ovf, res.word} = s; end
            CMD_DEC: begin s = saturate(wa - 1); {res.ovf, res.word} = s; end
            CMD_FROM_INT: begin
                s = saturate(wa <<< FracBits);
                {res.ovf, res.word} = s;
            end
            CMD_MUL, CMD_DIV: begin
                if (op == CMD_DIV && b == 0) begin
                    res.div_zero = 1'b1;
                end else begin
                    // round half away from zero on the magnitude
                    if (op == CMD_MUL)
                        mq = (ma * mb + (80'd1 << (FracBits - 1))) >> FracBits;
                    else
                        mq = (2 * (ma << FracBits) + mb) / (2 * mb);
                    q = ((a < 0) != (b < 0)) ? -$signed(mq) : $signed(mq);
                    s = saturate(q);
                    {res.ovf, res.word} = s;
                end
            end
            CMD_LT: res.cmp = a < b;
            CMD_GT: res.cmp = a > b;
            CMD_LE: res.cmp = a <= b;
            CMD_GE: res.cmp = a >= b;
            CMD_EQ: res.cmp = a == b;
            CMD_NE: res.cmp = a != b;
            CMD_MIN: res.word = (a < b) ? a : b;
            CMD_MAX: res.word = (a > b) ? a : b;
            default: res.word = a >>> FracBits;
        endcase
        return res;
    endfunction

    assign o_pending = expected_results.size();

    // predict on input transfers, compare on output transfers
    always @(posedge i_clk) begin
        t_alu_result got, want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            o_result_count <= 0;
        end else begin
            if (i_in_valid && i_in_ready)
                expected_results.push_back(compute_alu(t_cmd'(i_in_data[3:0]),
                    i_in_data[35:4], i_in_data[67:36]));
            if (i_out_valid && i_out_ready) begin
                got = t_alu_result'(i_out_data[34:0]);
                o_result_count <= o_result_count + 1;
                if (expected_results.size() == 0) begin
                    $error("result with no operation outstanding: %h", i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got != want) begin
                        o_fail_count <= o_fail_count + 1;
                        if (got.word != want.word)
                            $error("result_word expected %h got %h", want.word, got.word);
                        if (got.cmp != want.cmp)
                            $error("compare_true expected %0d got %0d", want.cmp, got.cmp);
                        if (got.ovf != want.ovf)
                            $error("overflowed expected %0d got %0d", want.ovf, got.ovf);
                        if (got.div_zero != want.div_zero)
                            $error("divide_by_zero expected %0d got %0d",
                                want.div_zero, got.div_zero);
                    end
                end
            end
        end
    end
endmodule

>>> tb/fixed_point_alu_tb.sv
// testbench top for the fixed-point alu: stimulus, back-pressure and verdict
module fixed_point_alu_tb
    import fpa_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RandomOps = 530;
    localparam int LatencyCycles = 43;
    localparam int IdleLimit = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;  // cmd, operand_a, operand_b
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;       // result_word, compare_true, overflowed, divide_by_zero
    int          fail_count, pending, result_count;
    bit          quiet_phase = 1'b0;
    bit          stimulus_done = 1'b0;
    int          idle_cycles = 0;
    int          op_count = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    fixed_point_alu uut (.*);

    fixed_point_alu_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready), .i_in_data(s_axis_tdata),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready), .i_out_data(m_axis_tdata),
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count)
    );

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (i_rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // interesting operand values
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'($urandom_range(0, 2)) - 32'd1;
            3: return 32'($urandom_range(0, 1023)) - 32'd512;
            4: return 32'($urandom_range(0, 32'h1ffff)) - 32'h10000;
            5: return 32'h7fffffff - 32'($urandom_range(0, 300));
            6: return 32'h80000000 + 32'($urandom_range(0, 300));
            default: return $urandom;
        endcase
    endfunction

    // offer one operation and wait for its transfer
    task automatic send_op(input t_cmd op, input logic [31:0] a, input logic [31:0] b);
        s_axis_tdata <= {4'b0, b, a, op};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        op_count++;
        @(negedge i_clk);
        if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
    endtask

    // receiver: random stalls, one long hold-off early on
    initial begin
        @(posedge i_rst_n);
        @(negedge i_clk);
        repeat (30) @(negedge i_clk);
        m_axis_tready <= 1'b0;
        repeat (150) @(negedge i_clk);
        forever begin
            if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(negedge i_clk);
            end
        end
    end

    // stimulus and verdict
    initial begin
        int wait_cycles;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // directed: every command with field extremes and rounding ties
        for (int c = 0; c < 16; c++)
            send_op(t_cmd'(c), 32'h7fffffff, 32'h80000000);
        send_op(CMD_DIV, 32'h00000100, 32'h00000000);
        send_op(CMD_MUL, 32'h00000080, 32'h00000001);
        send_op(CMD_MUL, 32'hffffff80, 32'h00000001);
        send_op(CMD_DIV, 32'h00000001, 32'h00000200);
        send_op(CMD_DIV, 32'h80000000, 32'hffffffff);
        send_op(CMD_INC, 32'h7fffffff, 32'hffffffff);
        send_op(CMD_DEC, 32'h80000000, 32'h0);
        send_op(CMD_FROM_INT, 32'hff800000, 32'h0);
        send_op(CMD_TO_INT, 32'hffffff01, 32'h0);
        // random part, last stretch without idling
        for (int i = 0; i < RandomOps; i++) begin
            if (i == RandomOps - 60) quiet_phase = 1'b1;
            send_op(t_cmd'($urandom_range(0, 15)), pick_operand(), pick_operand());
        end
        s_axis_tvalid <= 1'b0;
        stimulus_done = 1'b1;
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 20000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (LatencyCycles + 5) @(posedge i_clk);
        $display("covered %0d operations over all 16 commands, %0d results checked",
            op_count, result_count);
        $display("including saturation, rounding ties, divide by zero and back-pressure");
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
